>>> rtl/point_in_polygon_test_core_defines.svh
// ----------------------------------------------------------------------------
// Point-in-polygon test core: assertion macros
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH

// Same-cycle implication.
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PIP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon test core.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

  localparam int COORD_W          = 16;  // coordinate field width on the ports
  localparam int IDX_W            = 6;   // vertex_index field width
  localparam int CNT_W            = 7;   // vertex_count register width
  localparam int MIN_VERTICES     = 3;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // Tag that travels with one edge through the datapath.
  typedef struct packed {
    logic valid;
    logic last;
  } edge_tag_t;

  // Outcome of one edge.
  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } edge_res_t;

endpackage

`default_nettype wire

>>> rtl/pip_in_if.sv
// ----------------------------------------------------------------------------
// pip_in_if / pip_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_in_if
  import pip_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               action;
  logic [IDX_W-1:0]   vertex_index;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;

  modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic too_few_vertices;

  modport source (output valid, inside_res, too_few_vertices, input ready);
  modport sink   (input valid, inside_res, too_few_vertices, output ready);
endinterface

`default_nettype wire

>>> rtl/point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Even-odd ray-casting test of a point against a polygon kept in a vertex RAM.
// ----------------------------------------------------------------------------
//  port       dir  handshake     word
//  in_ch      in   valid/ready   action, vertex_index, coord_x, coord_y
//  out_ch     out  valid/ready   inside_res, too_few_vertices
//  cfg_*      in   cfg_we        vertex_count (7 bits)
//
//  A load is one RAM write.
//  A query with n >= 3 vertices makes n + 1 RAM reads through the
//  single read port (the closing vertex first), then runs the three-stage edge pipe.
//  A query with fewer vertices skips the RAM reads and answers too_few_vertices.
//  One word is worked on at a time; the result register lets the next word in
//  while a result waits. Reset clears control state only; the RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_in_polygon_test_core_defines.svh"

module point_in_polygon_test_core
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  pip_in_if.sink                in_ch,
  pip_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam int SW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cfg_cnt_r;
  logic [CW-1:0]      n_sat, n_r, n_m1;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic               few;
  logic               in_acc;
  logic [31:0]        idx_ext;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               walk_last;
  logic [2*SW-1:0]    store_mem [MAX_VERTICES];
  logic [2*SW-1:0]    rd_data_r, prev_r;
  logic               rd_v_r, rd_first_r, rd_last_r;
  logic [SW-1:0]      px_r, py_r;
  logic               par_r;
  logic               res_inside_r, res_few_r;
  logic               out_valid_r, out_inside_r, out_few_r;
  logic               slot_free;
  edge_tag_t          tag;
  edge_res_t          res;

  // -- configuration -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cnt_r <= '0;
    end else if (cfg_we) begin
      cfg_cnt_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (32'(cfg_cnt_r) > MAX_VERTICES) begin
      n_sat = CW'(MAX_VERTICES);
    end else begin
      n_sat = CW'(cfg_cnt_r);
    end
  end
  assign few  = 32'(n_sat) < MIN_VERTICES;
  assign n_m1 = n_sat - CW'(1);

  // -- input side ----------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign idx_ext     = 32'(in_ch.vertex_index);
  assign wr_en       = in_acc && (in_ch.action == ACT_LOAD) && (idx_ext < MAX_VERTICES);
  assign wr_addr     = idx_ext[AW-1:0];

  // -- read sequencing: closing vertex first, then 0 .. n-1 ----------------
  assign walk_last = (CW'(cnt_r) == n_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    rd_addr   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.action == ACT_QUERY)) begin
          if (few) begin
            state_nxt = ST_FINISH;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = n_m1[AW-1:0];
            cnt_nxt   = '0;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (walk_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.valid && res.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      rd_v_r     <= 1'b0;
      rd_first_r <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      rd_v_r     <= rd_en;
      rd_first_r <= rd_en && (state_r == ST_IDLE);
      rd_last_r  <= rd_en && (state_r == ST_WALK) && walk_last;
    end
  end

  // -- vertex RAM: {y, x} per entry ------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= {in_ch.coord_y[SW-1:0], in_ch.coord_x[SW-1:0]};
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  // hold query point and the previous vertex of the walk
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.action == ACT_QUERY)) begin
      px_r <= in_ch.coord_x[SW-1:0];
      py_r <= in_ch.coord_y[SW-1:0];
      n_r  <= n_sat;
    end
    if (rd_v_r) begin
      prev_r <= rd_data_r;
    end
  end

  // -- edge datapath ---------------------------------------------------------
  assign tag.valid = rd_v_r && !rd_first_r;
  assign tag.last  = rd_last_r;

  pip_edge_pipe #(
    .SW (SW)
  ) u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_in (tag),
    .px     (px_r),
    .py     (py_r),
    .xi     (rd_data_r[SW-1:0]),
    .yi     (rd_data_r[2*SW-1:SW]),
    .xj     (prev_r[SW-1:0]),
    .yj     (prev_r[2*SW-1:SW]),
    .res    (res)
  );

  // parity of crossings; capture the answer at the last edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r <= 1'b0;
    end else if (in_acc) begin
      par_r <= 1'b0;
    end else if (res.valid && res.hit) begin
      par_r <= ~par_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      res_inside_r <= 1'b0;
      res_few_r    <= 1'b1;
    end else if (res.valid && res.last) begin
      res_inside_r <= par_r ^ res.hit;
      res_few_r    <= 1'b0;
    end
  end

  // -- result register -------------------------------------------------------
  assign slot_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && slot_free) begin
      out_inside_r <= res_inside_r;
      out_few_r    <= res_few_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.inside_res       = out_inside_r;
  assign out_ch.too_few_vertices = out_few_r;

  // -- checks ----------------------------------------------------------------
  `PIP_ASSERT_IMP(a_walk_in_range, state_r == ST_WALK, CW'(cnt_r) < n_r,
    "walk counter ran past the vertex count")
  `PIP_ASSERT_IMP(a_edge_while_busy, res.valid,
    state_r == ST_WALK || state_r == ST_DRAIN, "edge result outside a walk")
  `PIP_ASSERT_NXT(a_query_walks, in_acc && in_ch.action == ACT_QUERY && !few,
    state_r == ST_WALK, "query with enough vertices did not start a walk")
  `PIP_ASSERT_NXT(a_finish_posts, state_r == ST_FINISH && slot_free,
    out_valid_r && state_r == ST_IDLE, "finished query not posted")

endmodule

`default_nettype wire

>>> rtl/pip_edge_pipe.sv
// ----------------------------------------------------------------------------
// pip_edge_pipe
// Three-stage crossing test of one polygon edge against a +x ray:
// differences, cross products, signed compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_pipe
  import pip_pkg::*;
#(
  parameter int SW = COORD_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire edge_tag_t     tag_in,
  input  wire logic [SW-1:0] px,
  input  wire logic [SW-1:0] py,
  input  wire logic [SW-1:0] xi,
  input  wire logic [SW-1:0] yi,
  input  wire logic [SW-1:0] xj,
  input  wire logic [SW-1:0] yj,
  output edge_res_t          res
);

  localparam int DW = SW + 1;
  localparam int PW = 2 * DW;

  edge_tag_t            tag1_r, tag2_r;
  logic                 cross1_r, cross2_r;
  logic                 dypos1_r, dypos2_r;
  logic signed [DW-1:0] a_r, dy_r, b_r, c_r;
  logic signed [PW-1:0] lhs_r, rhs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: straddle test and differences
    cross1_r <= (yi > py) != (yj > py);
    dypos1_r <= yj > yi;
    a_r      <= $signed({1'b0, px}) - $signed({1'b0, xi});
    dy_r     <= $signed({1'b0, yj}) - $signed({1'b0, yi});
    b_r      <= $signed({1'b0, xj}) - $signed({1'b0, xi});
    c_r      <= $signed({1'b0, py}) - $signed({1'b0, yi});
    // stage 2: cross products
    cross2_r <= cross1_r;
    dypos2_r <= dypos1_r;
    lhs_r    <= PW'(a_r) * PW'(dy_r);
    rhs_r    <= PW'(b_r) * PW'(c_r);
  end

  // stage 3: compare, sense follows the sign of dy
  always_comb begin
    res.valid = tag2_r.valid;
    res.last  = tag2_r.last;
    res.hit   = cross2_r & (dypos2_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r));
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test_core
// Self-checking bench for the point-in-polygon core. Polygons are loaded into
// the vertex store and the vertex count is changed between phases. Every
// query answer is checked against an even-odd ray-casting predictor; in some
// phases the source and the sink idle at random.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test_core;
  import pip_pkg::*;

  localparam int RANDOM_WORDS = 750;
  localparam int DRAIN_CYCLES = MAX_VERTICES_DEF + 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic               action;
    logic [IDX_W-1:0]   slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } word_t;

  typedef struct packed {
    logic in_poly;
    logic too_few;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  pip_in_if  in_ch ();
  pip_out_if out_ch ();

  word_t    word_q[$];     // words waiting to be offered
  verdict_t verdict_q[$];  // answers owed by the core, oldest first
  word_t    next_word;
  verdict_t want;

  // Predictor copy of the store and the count register.
  logic [COORD_W-1:0] poly_x [MAX_VERTICES_DEF];
  logic [COORD_W-1:0] poly_y [MAX_VERTICES_DEF];
  logic [CNT_W-1:0]   poly_count;

  // Vertices as queued, used to aim query points at vertex heights.
  logic [COORD_W-1:0] aim_x [MAX_VERTICES_DEF];
  logic [COORD_W-1:0] aim_y [MAX_VERTICES_DEF];

  int          send_idle_pct;
  int          stall_pct;
  int          queued_words;
  int          mismatches = 0;
  int          hold_left;
  logic        hold_req;
  logic        hold_taken;
  int unsigned cycle_count = 0;

  point_in_polygon_test_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Edge (j, i) crosses the +x ray from the point; exact cross-multiplied test.
  function automatic bit ray_hits_edge(longint px, longint py, longint xi, longint yi,
                                       longint xj, longint yj);
    longint dy;
    longint lhs;
    longint rhs;
    if ((yi > py) == (yj > py)) return 1'b0;
    dy  = yj - yi;
    lhs = (px - xi) * dy;
    rhs = (xj - xi) * (py - yi);
    if (dy > 0) return lhs < rhs;
    return lhs > rhs;
  endfunction

  function automatic verdict_t even_odd_verdict(logic [COORD_W-1:0] px,
                                                logic [COORD_W-1:0] py);
    int       n;
    int       j;
    verdict_t v;
    v = '0;
    n = (poly_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(poly_count);
    if (n < MIN_VERTICES) begin
      v.too_few = 1'b1;
      return v;
    end
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      if (ray_hits_edge(px, py, poly_x[i], poly_y[i], poly_x[j], poly_y[j]))
        v.in_poly = ~v.in_poly;
      j = i;
    end
    return v;
  endfunction

  // kind 0: any value, 1: frame edges and midline, 2: coarse grid
  function automatic logic [COORD_W-1:0] pick_coord(int kind);
    case (kind)
      0: return COORD_W'($urandom);
      1: begin
        case ($urandom_range(5))
          0:       return 16'h0000;
          1:       return 16'h0001;
          2:       return 16'h7FFF;
          3:       return 16'h8000;
          4:       return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
      default: return COORD_W'($urandom_range(15) * 4096);
    endcase
  endfunction

  task automatic queue_word(logic act, logic [IDX_W-1:0] slot,
                            logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    word_q.push_back('{action: act, slot: slot, x: x, y: y});
    if (act == ACT_LOAD) begin
      aim_x[slot] = x;
      aim_y[slot] = y;
    end
    queued_words++;
  endtask

  // sample at the falling edge, after the rising-edge updates have settled
  task automatic wait_drained();
    while (word_q.size() != 0 || in_ch.valid || verdict_q.size() != 0) @(negedge clk);
    // loads give no answer; let the last one settle too
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Driver: offer queued words, predict each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.action       <= ACT_LOAD;
      in_ch.vertex_index <= '0;
      in_ch.coord_x      <= '0;
      in_ch.coord_y      <= '0;
      poly_count = '0;
    end else begin
      if (cfg_we) poly_count = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_LOAD) begin
          poly_x[in_ch.vertex_index] = in_ch.coord_x;
          poly_y[in_ch.vertex_index] = in_ch.coord_y;
        end else begin
          verdict_q.push_back(even_odd_verdict(in_ch.coord_x, in_ch.coord_y));
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = word_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.action       <= next_word.action;
          in_ch.vertex_index <= next_word.slot;
          in_ch.coord_x      <= next_word.x;
          in_ch.coord_y      <= next_word.y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long sink hold-off, started once on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end
  end

  // Monitor: check each answer against the oldest owed verdict.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          if (mismatches < MAX_SHOWN)
            $display("unexpected result word: inside_res=%0b too_few_vertices=%0b",
                     out_ch.inside_res, out_ch.too_few_vertices);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.inside_res !== want.in_poly ||
              out_ch.too_few_vertices !== want.too_few) begin
            if (mismatches < MAX_SHOWN)
              $display({"result mismatch: inside_res exp %0b got %0b, ",
                        "too_few_vertices exp %0b got %0b"},
                       want.in_poly, out_ch.inside_res, want.too_few,
                       out_ch.too_few_vertices);
            mismatches++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && !(hold_req && !hold_taken) &&
                      ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int                 ph;
    int                 count;
    int                 m;
    int                 shape;
    int                 kind;
    int                 v;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    hold_req           <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    queued_words  = 0;
    for (int s = 0; s < MAX_VERTICES_DEF; s++) begin
      aim_x[s] = '0;
      aim_y[s] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Count is zero out of reset: queries answer too few, loads only fill slots.
    queue_word(ACT_QUERY, 6'd63, 16'hFFFF, 16'hFFFF);
    queue_word(ACT_LOAD,  6'd63, 16'hFFFF, 16'hFFFF);
    queue_word(ACT_LOAD,  6'd0,  16'h0000, 16'h0000);
    queue_word(ACT_QUERY, 6'd0,  16'h0000, 16'h0000);
    wait_drained();
    write_count(2);
    queue_word(ACT_QUERY, 6'd21, 16'h8000, 16'h8000);
    wait_drained();

    // Full-frame square, probed at its center, corners and sides.
    write_count(4);
    queue_word(ACT_LOAD,  6'd0,  16'h0000, 16'h0000);
    queue_word(ACT_LOAD,  6'd1,  16'hFFFF, 16'h0000);
    queue_word(ACT_LOAD,  6'd2,  16'hFFFF, 16'hFFFF);
    queue_word(ACT_LOAD,  6'd3,  16'h0000, 16'hFFFF);
    queue_word(ACT_QUERY, 6'd42, 16'h8000, 16'h8000);
    queue_word(ACT_QUERY, 6'd0,  16'h0000, 16'h0000);
    queue_word(ACT_QUERY, 6'd0,  16'hFFFF, 16'hFFFF);
    queue_word(ACT_QUERY, 6'd0,  16'h0000, 16'h8000);
    queue_word(ACT_QUERY, 6'd0,  16'hFFFE, 16'h8000);
    queue_word(ACT_QUERY, 6'd0,  16'h8000, 16'h0000);
    queue_word(ACT_QUERY, 6'd0,  16'h8000, 16'hFFFE);
    wait_drained();

    // Triangle with its apex on the bottom row: rays through a vertex.
    write_count(3);
    queue_word(ACT_LOAD,  6'd0,  16'h0000, 16'hFFFF);
    queue_word(ACT_LOAD,  6'd1,  16'hFFFF, 16'hFFFF);
    queue_word(ACT_LOAD,  6'd2,  16'h8000, 16'h0000);
    queue_word(ACT_QUERY, 6'd0,  16'h8000, 16'h8000);
    queue_word(ACT_QUERY, 6'd0,  16'h8000, 16'h0000);
    queue_word(ACT_QUERY, 6'd0,  16'h0000, 16'h8000);
    queue_word(ACT_QUERY, 6'd0,  16'hFFFF, 16'h0001);
    wait_drained();

    queued_words = 0;
    ph = 0;
    while (queued_words < RANDOM_WORDS) begin
      case (ph)
        0: count = 3;
        1: count = MAX_VERTICES_DEF;
        2: count = 127;
        3: count = 1;
        default: begin
          case ($urandom_range(9))
            0:       count = $urandom_range(2);
            1:       count = $urandom_range(127, MAX_VERTICES_DEF);
            default: count = $urandom_range(12, MIN_VERTICES);
          endcase
        end
      endcase
      write_count(count);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 56; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase

      // Fill every slot in use before any query reads it.
      m = (count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : count;
      shape = $urandom_range(2);
      if (m >= MIN_VERTICES)
        for (int s = 0; s < m; s++)
          queue_word(ACT_LOAD, IDX_W'(s), pick_coord(shape), pick_coord(shape));

      repeat ($urandom_range(24, 6)) begin
        if ($urandom_range(99) < 12) begin
          queue_word(ACT_LOAD, IDX_W'($urandom_range(63)), pick_coord(0), pick_coord(0));
        end else begin
          kind = $urandom_range(3);
          if (kind < 3) begin
            qx = pick_coord(kind);
            qy = pick_coord(kind);
          end else begin
            // land on a vertex height, just beside a vertex column
            v  = $urandom_range((m >= MIN_VERTICES) ? m - 1 : 63);
            qx = aim_x[v] + COORD_W'($urandom_range(4)) - COORD_W'(2);
            v  = $urandom_range((m >= MIN_VERTICES) ? m - 1 : 63);
            qy = aim_y[v];
          end
          queue_word(ACT_QUERY, IDX_W'($urandom_range(63)), qx, qy);
        end
      end

      // Hold the sink off while the source keeps offering: fills the core.
      if (ph == 0) hold_req <= 1'b1;
      wait_drained();
      ph++;
    end

    if (mismatches == 0 && verdict_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_in_if.sv
rtl/pip_edge_pipe.sv
rtl/point_in_polygon_test_core.sv
tb/sv/tb_point_in_polygon_test_core.sv
